>>> design/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg: shared definitions for the row box filter
// Sample and pixel widths, channel limit and radius register layout.
// ----------------------------------------------------------------------------
package bbr_pkg;

	// one channel sample and the packed RGBA pixel
	localparam int SAMPLE_W = 16;
	localparam int NUM_CH   = 4;
	localparam int PIX_W    = SAMPLE_W * NUM_CH;

	// means are limited to the channel range
	localparam int CHAN_BITS = 16;
	localparam logic [SAMPLE_W-1:0] CHAN_MAX = SAMPLE_W'((1 << CHAN_BITS) - 1);

	// radius register
	localparam int RADIUS_W = 6;
	localparam int RADIUS_LIMIT = (1 << RADIUS_W) - 1;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);
	localparam int MAX_RADIUS_DEF = 63;

	// answers given in the current row, wraps
	localparam int OUT_CNT_W = 16;

endpackage

>>> design/bbr_div.sv
// ----------------------------------------------------------------------------
// bbr_div: iterative window divider
// Restoring division, one quotient bit per cycle. The quotient is known to
// fit in one sample, so the upper dividend bits seed the remainder.
// ----------------------------------------------------------------------------
module bbr_div #(
	parameter int DIVISOR_W = 7
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [bbr_pkg::SAMPLE_W+DIVISOR_W-1:0]  dividend,
	input  logic [DIVISOR_W-1:0]                    divisor,
	output logic                                    done,
	output logic [bbr_pkg::SAMPLE_W-1:0]            quot
);

	localparam int Q_W   = bbr_pkg::SAMPLE_W;
	localparam int CNT_W = $clog2(Q_W);

	logic [DIVISOR_W-1:0] rem_q;
	logic [Q_W-1:0]       dvd_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 fits;

	// one trial subtraction per cycle
	assign trial = {rem_q, dvd_q[Q_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= dividend[Q_W+DIVISOR_W-1:Q_W];
				dvd_q  <= dividend[Q_W-1:0];
				dsr_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
				dvd_q <= {dvd_q[Q_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = dvd_q;

endmodule

>>> design/box_blur_row.sv
// ----------------------------------------------------------------------------
// box_blur_row: horizontal box filter over one RGBA row, clamped edges
// Streams pixels of a row and returns the truncated window mean per channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one RGBA pixel per request, the
//   last pixel of a row flagged with row_end. Output channel
//   (out_valid/out_ready) returns one mean pixel per request, row_done on
//   the last one of the row. Answers lag the input by r = min(radius,
//   MAX_RADIUS) pixels; the row_end pixel flushes all answers still owed.
//   The cfg channel writes the 6-bit radius; it takes effect on the next
//   accepted pixel. Radius resets to 1.
//   Sequence: a pixel is accepted in the idle step, then checked. Each
//   answer it releases needs a window accumulation (one ring read per
//   window position), four divisions through the single shared divider,
//   then an emit and a check step. in_ready is low for the whole time.
//   When the receiver stalls, the block holds in its emit step with the
//   finished answer until the output register frees up.
//   Reset clears the row position counters; the pixel ring needs no clearing.
// ----------------------------------------------------------------------------
module box_blur_row #(
	parameter int MAX_RADIUS = bbr_pkg::MAX_RADIUS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bbr_pkg::RADIUS_W-1:0]     cfg_data,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bbr_pkg::SAMPLE_W-1:0]     red_in,
	input  logic [bbr_pkg::SAMPLE_W-1:0]     green_in,
	input  logic [bbr_pkg::SAMPLE_W-1:0]     blue_in,
	input  logic [bbr_pkg::SAMPLE_W-1:0]     alpha_in,
	input  logic                             row_end,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bbr_pkg::SAMPLE_W-1:0]     red_out,
	output logic [bbr_pkg::SAMPLE_W-1:0]     green_out,
	output logic [bbr_pkg::SAMPLE_W-1:0]     blue_out,
	output logic [bbr_pkg::SAMPLE_W-1:0]     alpha_out,
	output logic                             row_done
);

	localparam int SW    = bbr_pkg::SAMPLE_W;
	localparam int NCH   = bbr_pkg::NUM_CH;
	localparam int PW    = bbr_pkg::PIX_W;
	localparam int RMAX  = (MAX_RADIUS < bbr_pkg::RADIUS_LIMIT) ?
		MAX_RADIUS : bbr_pkg::RADIUS_LIMIT;
	localparam int R_W   = $clog2(RMAX + 1);
	localparam int WIN_W = R_W + 1;
	localparam int SUM_W = SW + WIN_W;
	localparam int AW    = $clog2(2 * RMAX + 2);
	localparam int DEPTH = 1 << AW;
	localparam int PS_W  = $clog2(RMAX + 2);
	localparam int OC_W  = bbr_pkg::OUT_CNT_W;
	localparam int LP_W  = OC_W + 1;
	localparam int P_W   = LP_W + 1;
	localparam int CH_W  = $clog2(NCH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ACC,
		S_DIV_GO,
		S_DIV_WAIT,
		S_EMIT
	} state_t;

	state_t                     state_q;
	logic [bbr_pkg::RADIUS_W-1:0] radius_q;
	logic [R_W-1:0]             r_q;
	logic [PS_W-1:0]            ps_q;
	logic [OC_W-1:0]            od_q;
	logic [LP_W-1:0]            cen_q;
	logic [LP_W-1:0]            last_q;
	logic                       end_q;
	logic [PW-1:0]              first_q;
	logic signed [P_W-1:0]      pp_q;
	logic [WIN_W-1:0]           k_q;
	logic [CH_W-1:0]            ch_q;
	logic [SUM_W-1:0]           sum_q [NCH];
	logic [SW-1:0]              mean_q [NCH];
	logic                       acc_vld_s1;
	logic                       first_s1;
	logic [PW-1:0]              rd_s1;

	logic                       out_valid_q;
	logic [SW-1:0]              red_q;
	logic [SW-1:0]              green_q;
	logic [SW-1:0]              blue_q;
	logic [SW-1:0]              alpha_q;
	logic                       done_q;

	logic [PW-1:0]              ring_mem [DEPTH];

	logic [R_W-1:0]             r_cfg;
	logic [WIN_W-1:0]           win;
	logic [PW-1:0]              in_px;
	logic [LP_W-1:0]            pos_in;
	logic                       in_acc;
	logic                       pp_over;
	logic [AW-1:0]              rd_addr;
	logic                       issue;
	logic [PW-1:0]              acc_px;
	logic                       div_start;
	logic                       div_done;
	logic [SW-1:0]              div_quot;
	logic [SW-1:0]              mean_lim;

	// handshakes
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;

	// radius in use and window size 2r+1
	assign r_cfg = (radius_q > RMAX) ? R_W'(RMAX) : radius_q[R_W-1:0];
	assign win   = {r_q, 1'b1};

	assign in_px  = {alpha_in, blue_in, green_in, red_in};
	assign pos_in = LP_W'(od_q) + LP_W'(ps_q);

	// window position: left of the row reads the first pixel, right of it
	// reads the last one
	assign pp_over = (pp_q > $signed({1'b0, last_q}));
	assign rd_addr = pp_over ? last_q[AW-1:0] : pp_q[AW-1:0];
	assign issue   = (state_q == S_ACC) && (k_q != win);
	assign acc_px  = first_s1 ? first_q : rd_s1;

	// pixel ring, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ring_mem[pos_in[AW-1:0]] <= in_px;
		end
		rd_s1 <= ring_mem[rd_addr];
	end

	// shared divider, one channel at a time
	assign div_start = (state_q == S_DIV_GO);

	bbr_div #(
		.DIVISOR_W (WIN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[ch_q]),
		.divisor  (win),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign mean_lim = (div_quot > bbr_pkg::CHAN_MAX) ? bbr_pkg::CHAN_MAX : div_quot;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			radius_q    <= bbr_pkg::RADIUS_RESET;
			r_q         <= '0;
			ps_q        <= '0;
			od_q        <= '0;
			cen_q       <= '0;
			last_q      <= '0;
			end_q       <= 1'b0;
			first_q     <= '0;
			pp_q        <= '0;
			k_q         <= '0;
			ch_q        <= '0;
			sum_q       <= '{default: '0};
			mean_q      <= '{default: '0};
			acc_vld_s1  <= 1'b0;
			first_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
			alpha_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				radius_q <= cfg_data;
			end
			if (out_valid_q && out_ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			acc_vld_s1 <= issue;
			first_s1   <= pp_q[P_W-1];

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (ps_q == '0 && od_q == '0) begin
							first_q <= in_px;
						end
						last_q  <= pos_in;
						cen_q   <= LP_W'(od_q);
						ps_q    <= ps_q + 1'b1;
						end_q   <= row_end;
						r_q     <= r_cfg;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (end_q ? (ps_q != '0) : (ps_q > r_q)) begin
						pp_q    <= $signed({1'b0, cen_q}) - $signed(P_W'(r_q));
						k_q     <= '0;
						sum_q   <= '{default: '0};
						state_q <= S_ACC;
					end else begin
						if (end_q) begin
							od_q <= '0;
							ps_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_ACC: begin
					if (issue) begin
						pp_q <= pp_q + P_W'(1);
						k_q  <= k_q + 1'b1;
					end
					if (acc_vld_s1) begin
						for (int c = 0; c < NCH; c++) begin
							sum_q[c] <= sum_q[c] + SUM_W'(acc_px[c*SW +: SW]);
						end
					end
					if (!issue) begin
						ch_q    <= '0;
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						mean_q[ch_q] <= mean_lim;
						if (ch_q == CH_W'(NCH - 1)) begin
							state_q <= S_EMIT;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						red_q       <= mean_q[0];
						green_q     <= mean_q[1];
						blue_q      <= mean_q[2];
						alpha_q     <= mean_q[3];
						done_q      <= end_q && (ps_q == PS_W'(1));
						out_valid_q <= 1'b1;
						ps_q        <= ps_q - 1'b1;
						if (!end_q) begin
							od_q <= od_q + 1'b1;
						end
						cen_q   <= cen_q + 1'b1;
						state_q <= S_CHECK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign alpha_out = alpha_q;
	assign row_done  = done_q;

	// pending pixels never exceed one more than the largest radius
	a_ps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ps_q <= PS_W'(RMAX + 1))
		else $error("pending pixel count out of range");

	// no answer owed mid-row: go straight back to take the next pixel
	a_check_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) && !end_q && !(ps_q > r_q) |=> (state_q == S_IDLE))
		else $error("check step did not return to idle");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_WAIT))
		else $error("divider result outside wait step");

endmodule
